// ===== rtl/gse_pkg.sv =====
package gse_pkg;

    // Frame layout
    localparam int unsigned FrameLen    = 416;
    localparam int unsigned SectorBytes = 256;
    localparam int unsigned AuxCount    = 86;
    localparam int unsigned DataStart   = 54;
    localparam int unsigned UpperStart  = DataStart + AuxCount;
    localparam int unsigned CheckPos    = UpperStart + SectorBytes;
    localparam int unsigned AuxThirdEnd = DataStart + SectorBytes - 2 * AuxCount;

    localparam logic [7:0] SyncByte  = 8'hFF;
    localparam logic [7:0] MarkD5    = 8'hD5;
    localparam logic [7:0] MarkAA    = 8'hAA;
    localparam logic [7:0] Mark96    = 8'h96;
    localparam logic [7:0] MarkAD    = 8'hAD;
    localparam logic [7:0] MarkDE    = 8'hDE;
    localparam logic [7:0] MarkEB    = 8'hEB;
    localparam logic [7:0] Mask55    = 8'h55;
    localparam logic [5:0] Mask3F    = 6'h3F;
    localparam logic [7:0] VolumeRst = 8'd254;

    // Memory address bias added to the low byte of the frame index
    localparam logic [7:0] BiasAux0  = 8'(SectorBytes - DataStart);
    localparam logic [7:0] BiasAux1  = 8'(AuxCount - DataStart);
    localparam logic [7:0] BiasAux2  = 8'(2 * AuxCount - DataStart);
    localparam logic [7:0] BiasUpper = 8'(SectorBytes - UpperStart);

    // Microprogram step addresses
    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_LOAD  = 4'd1,
        S_PULL  = 4'd2,
        S_NRDY  = 4'd3,
        S_CONST = 4'd4,
        S_AUX0  = 4'd5,
        S_AUX1  = 4'd6,
        S_AUX2  = 4'd7,
        S_AUX3  = 4'd8,
        S_CHAIN = 4'd9,
        S_UP0   = 4'd10,
        S_UP1   = 4'd11
    } step_t;

    typedef enum logic [1:0] {
        JMP_GOTO,
        JMP_ACCEPT,
        JMP_PULL
    } jmp_t;

    typedef enum logic [1:0] {
        ADDR_AUX0,
        ADDR_AUX1,
        ADDR_AUX2,
        ADDR_UPPER
    } addr_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_SW0,
        ACC_SW1,
        ACC_SW2,
        ACC_UPPER
    } acc_op_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_STORE,
        DP_NOT_READY,
        DP_EMIT_CONST,
        DP_EMIT_CHAIN
    } dp_op_t;

    typedef enum logic [1:0] {
        REG_CONST,
        REG_AUX,
        REG_UPPER
    } region_t;

    typedef struct packed {
        jmp_t      jmp;
        step_t     target;
        addr_sel_t addr;
        acc_op_t   acc;
        dp_op_t    dp;
    } ctrl_t;

    typedef struct packed {
        logic    loaded;
        region_t region;
    } dp_status_t;

    // Control store
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w = '{jmp: JMP_GOTO, target: S_IDLE, addr: ADDR_AUX0, acc: ACC_NONE, dp: DP_NONE};
        case (s)
            S_IDLE:
            begin
                w.jmp = JMP_ACCEPT;
                w.dp  = DP_CAPTURE;
            end
            S_LOAD:
            begin
                w.dp = DP_STORE;
            end
            S_PULL:
            begin
                w.jmp = JMP_PULL;
            end
            S_NRDY:
            begin
                w.dp = DP_NOT_READY;
            end
            S_CONST:
            begin
                w.dp = DP_EMIT_CONST;
            end
            S_AUX0:
            begin
                w.target = S_AUX1;
                w.addr   = ADDR_AUX0;
            end
            S_AUX1:
            begin
                w.target = S_AUX2;
                w.addr   = ADDR_AUX1;
                w.acc    = ACC_SW0;
            end
            S_AUX2:
            begin
                w.target = S_AUX3;
                w.addr   = ADDR_AUX2;
                w.acc    = ACC_SW1;
            end
            S_AUX3:
            begin
                w.target = S_CHAIN;
                w.acc    = ACC_SW2;
            end
            S_CHAIN:
            begin
                w.dp = DP_EMIT_CHAIN;
            end
            S_UP0:
            begin
                w.target = S_UP1;
                w.addr   = ADDR_UPPER;
            end
            S_UP1:
            begin
                w.target = S_CHAIN;
                w.acc    = ACC_UPPER;
            end
            default:
            begin
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] gcr_code(logic [5:0] v);
        logic [7:0] r;
        case (v)
            6'd0:  r = 8'h96; 6'd1:  r = 8'h97; 6'd2:  r = 8'h9A; 6'd3:  r = 8'h9B;
            6'd4:  r = 8'h9D; 6'd5:  r = 8'h9E; 6'd6:  r = 8'h9F; 6'd7:  r = 8'hA6;
            6'd8:  r = 8'hA7; 6'd9:  r = 8'hAB; 6'd10: r = 8'hAC; 6'd11: r = 8'hAD;
            6'd12: r = 8'hAE; 6'd13: r = 8'hAF; 6'd14: r = 8'hB2; 6'd15: r = 8'hB3;
            6'd16: r = 8'hB4; 6'd17: r = 8'hB5; 6'd18: r = 8'hB6; 6'd19: r = 8'hB7;
            6'd20: r = 8'hB9; 6'd21: r = 8'hBA; 6'd22: r = 8'hBB; 6'd23: r = 8'hBC;
            6'd24: r = 8'hBD; 6'd25: r = 8'hBE; 6'd26: r = 8'hBF; 6'd27: r = 8'hCB;
            6'd28: r = 8'hCD; 6'd29: r = 8'hCE; 6'd30: r = 8'hCF; 6'd31: r = 8'hD3;
            6'd32: r = 8'hD6; 6'd33: r = 8'hD7; 6'd34: r = 8'hD9; 6'd35: r = 8'hDA;
            6'd36: r = 8'hDB; 6'd37: r = 8'hDC; 6'd38: r = 8'hDD; 6'd39: r = 8'hDE;
            6'd40: r = 8'hDF; 6'd41: r = 8'hE5; 6'd42: r = 8'hE6; 6'd43: r = 8'hE7;
            6'd44: r = 8'hE9; 6'd45: r = 8'hEA; 6'd46: r = 8'hEB; 6'd47: r = 8'hEC;
            6'd48: r = 8'hED; 6'd49: r = 8'hEE; 6'd50: r = 8'hEF; 6'd51: r = 8'hF2;
            6'd52: r = 8'hF3; 6'd53: r = 8'hF4; 6'd54: r = 8'hF5; 6'd55: r = 8'hF6;
            6'd56: r = 8'hF7; 6'd57: r = 8'hF9; 6'd58: r = 8'hFA; 6'd59: r = 8'hFB;
            6'd60: r = 8'hFC; 6'd61: r = 8'hFD; 6'd62: r = 8'hFE; 6'd63: r = 8'hFF;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code44(logic [7:0] v, logic hi);
        return hi ? (((v >> 1) & Mask55) | MarkAA) : ((v & Mask55) | MarkAA);
    endfunction

    function automatic logic [1:0] swap2(logic [7:0] b);
        return {b[0], b[1]};
    endfunction

    // Every frame byte that is not a chained data value
    function automatic logic [7:0] frame_const(logic [8:0] idx, logic [7:0] vol,
                                               logic [7:0] trk, logic [3:0] sec,
                                               logic [5:0] chain);
        logic [7:0] sec8;
        logic [7:0] sum;
        logic [7:0] r;
        sec8 = {4'd0, sec};
        sum  = vol ^ trk ^ sec8;
        if (idx < 9'd29)                     r = SyncByte;
        else if (idx == 9'd29)               r = MarkD5;
        else if (idx == 9'd30)               r = MarkAA;
        else if (idx == 9'd31)               r = Mark96;
        else if (idx < 9'd34)                r = code44(vol, idx == 9'd32);
        else if (idx < 9'd36)                r = code44(trk, idx == 9'd34);
        else if (idx < 9'd38)                r = code44(sec8, idx == 9'd36);
        else if (idx < 9'd40)                r = code44(sum, idx == 9'd38);
        else if (idx == 9'd40)               r = MarkDE;
        else if (idx == 9'd41)               r = MarkAA;
        else if (idx == 9'd42)               r = MarkEB;
        else if (idx < 9'd51)                r = SyncByte;
        else if (idx == 9'd51)               r = MarkD5;
        else if (idx == 9'd52)               r = MarkAA;
        else if (idx == 9'd53)               r = MarkAD;
        else if (idx == 9'(CheckPos))        r = gcr_code(chain);
        else if (idx == 9'(CheckPos + 1))    r = MarkDE;
        else if (idx == 9'(CheckPos + 2))    r = MarkAA;
        else if (idx == 9'(CheckPos + 3))    r = MarkEB;
        else                                 r = SyncByte;
        return r;
    endfunction

endpackage

// ===== rtl/gcr_six_and_two_sector_encoder_core.sv =====
// Six-and-two GCR sector frame encoder; one request at a time, start taken while busy is low.
// Load request: no result. Pull request: result strobed on done in the cycle after the emit step,
// which follows the dispatch directly for header/sync/checksum bytes and not-ready; auxiliary values
// first take three reads of the sector RAM read port, upper values one. Results cannot be stalled.
// Reset (async, rst_n low) clears the step counter, counts, chain, latched header and sets
// volume to 254; the sector RAM is not cleared and its data is used only after a full sector load.
module gcr_six_and_two_sector_encoder_core (
    input  logic       clk,
    input  logic       rst_n,

    // request channel
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] data_byte,
    input  logic [7:0] track,
    input  logic [3:0] sector,

    // volume register write
    input  logic       volume_we,
    input  logic [7:0] volume_wdata,

    // result channel, one-cycle strobe
    output logic       done,
    output logic [7:0] nibble,
    output logic       last_of_sector,
    output logic       status
);

    // Control word from the microprogram ROM, status flags back for the jumps
    gse_pkg::ctrl_t      ctrl;
    gse_pkg::dp_status_t stat;

    // Step counter + control store. Step 0 dispatches a request by action;
    // the pull step dispatches again on load state and frame region.
    gse_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // Sector RAM, counters, XOR chain, GCR/4-and-4 coding and result registers
    gse_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .start          (start),
        .data_byte      (data_byte),
        .track          (track),
        .sector         (sector),
        .volume_we      (volume_we),
        .volume_wdata   (volume_wdata),
        .stat           (stat),
        .done           (done),
        .nibble         (nibble),
        .last_of_sector (last_of_sector),
        .status         (status)
    );

endmodule

// ===== rtl/gse_useq.sv =====
module gse_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  gse_pkg::dp_status_t stat,
    output gse_pkg::ctrl_t      ctrl,
    output logic                busy
);

    gse_pkg::step_t step_reg;
    gse_pkg::step_t step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= gse_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctrl      = gse_pkg::ucode(step_reg);
        busy      = (step_reg != gse_pkg::S_IDLE);
        step_next = ctrl.target;
        case (ctrl.jmp)
            gse_pkg::JMP_ACCEPT:
            begin
                if (start)
                begin
                    step_next = action ? gse_pkg::S_PULL : gse_pkg::S_LOAD;
                end
            end
            gse_pkg::JMP_PULL:
            begin
                if (!stat.loaded)
                begin
                    step_next = gse_pkg::S_NRDY;
                end
                else
                begin
                    case (stat.region)
                        gse_pkg::REG_AUX:   step_next = gse_pkg::S_AUX0;
                        gse_pkg::REG_UPPER: step_next = gse_pkg::S_UP0;
                        default:            step_next = gse_pkg::S_CONST;
                    endcase
                end
            end
            default:
            begin
                step_next = ctrl.target;
            end
        endcase
    end

endmodule

// ===== rtl/gse_datapath.sv =====
module gse_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gse_pkg::ctrl_t      ctrl,
    input  logic                start,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          track,
    input  logic [3:0]          sector,
    input  logic                volume_we,
    input  logic [7:0]          volume_wdata,
    output gse_pkg::dp_status_t stat,
    output logic                done,
    output logic [7:0]          nibble,
    output logic                last_of_sector,
    output logic                status
);

    logic [7:0] mem [gse_pkg::SectorBytes];
    logic [7:0] rdata_reg;
    logic [7:0] rd_addr;
    logic [7:0] bias;

    logic [7:0] volume_reg;
    logic [8:0] load_count_reg, load_count_next;
    logic [8:0] emit_index_reg, emit_index_next;
    logic [5:0] chain_reg, chain_next;
    logic [7:0] track_reg, track_next;
    logic [3:0] sector_reg, sector_next;
    logic       done_reg, done_next;

    logic [7:0] in_data_reg;
    logic [7:0] in_track_reg;
    logic [3:0] in_sector_reg;
    logic [5:0] acc_reg, acc_next;
    logic [7:0] nibble_reg, nibble_next;
    logic       last_reg, last_next;
    logic       status_reg, status_next;

    logic       emit;
    logic       is_last;
    logic       mem_we;

    always_comb
    begin
        case (ctrl.addr)
            gse_pkg::ADDR_AUX1:  bias = gse_pkg::BiasAux1;
            gse_pkg::ADDR_AUX2:  bias = gse_pkg::BiasAux2;
            gse_pkg::ADDR_UPPER: bias = gse_pkg::BiasUpper;
            default:             bias = gse_pkg::BiasAux0;
        endcase
        rd_addr = emit_index_reg[7:0] + bias;
    end

    assign mem_we = (ctrl.dp == gse_pkg::DP_STORE) && !load_count_reg[8];

    // Sector store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[load_count_reg[7:0]] <= in_data_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        stat.loaded = load_count_reg[8];
        if (emit_index_reg < 9'(gse_pkg::DataStart) || emit_index_reg >= 9'(gse_pkg::CheckPos))
        begin
            stat.region = gse_pkg::REG_CONST;
        end
        else if (emit_index_reg < 9'(gse_pkg::UpperStart))
        begin
            stat.region = gse_pkg::REG_AUX;
        end
        else
        begin
            stat.region = gse_pkg::REG_UPPER;
        end
    end

    // Value accumulator for aux and upper values
    always_comb
    begin
        acc_next = acc_reg;
        case (ctrl.acc)
            gse_pkg::ACC_SW0:   acc_next = {4'd0, gse_pkg::swap2(rdata_reg)};
            gse_pkg::ACC_SW1:   acc_next = acc_reg | {2'd0, gse_pkg::swap2(rdata_reg), 2'd0};
            gse_pkg::ACC_SW2:
            begin
                if (emit_index_reg < 9'(gse_pkg::AuxThirdEnd))
                begin
                    acc_next = acc_reg | {gse_pkg::swap2(rdata_reg), 4'd0};
                end
            end
            gse_pkg::ACC_UPPER: acc_next = rdata_reg[7:2];
            default:            acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        emit_index_next = emit_index_reg;
        chain_next      = chain_reg;
        track_next      = track_reg;
        sector_next     = sector_reg;
        done_next       = 1'b0;
        nibble_next     = nibble_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        emit            = 1'b0;
        is_last         = (emit_index_reg == 9'(gse_pkg::FrameLen - 1));

        case (ctrl.dp)
            gse_pkg::DP_STORE:
            begin
                if (!load_count_reg[8])
                begin
                    if (load_count_reg == 9'd0)
                    begin
                        track_next  = in_track_reg;
                        sector_next = in_sector_reg;
                    end
                    load_count_next = load_count_reg + 9'd1;
                end
            end
            gse_pkg::DP_NOT_READY:
            begin
                done_next   = 1'b1;
                nibble_next = 8'd0;
                last_next   = 1'b0;
                status_next = 1'b1;
            end
            gse_pkg::DP_EMIT_CONST:
            begin
                emit        = 1'b1;
                nibble_next = gse_pkg::frame_const(emit_index_reg, volume_reg, track_reg,
                                                   sector_reg, chain_reg);
                // data prologue restarts the chain
                if (emit_index_reg >= 9'd51 && emit_index_reg < 9'(gse_pkg::DataStart))
                begin
                    chain_next = 6'd0;
                end
            end
            gse_pkg::DP_EMIT_CHAIN:
            begin
                emit        = 1'b1;
                nibble_next = gse_pkg::gcr_code((chain_reg ^ acc_reg) & gse_pkg::Mask3F);
                chain_next  = acc_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit)
        begin
            done_next   = 1'b1;
            status_next = 1'b0;
            last_next   = is_last;
            if (is_last)
            begin
                emit_index_next = 9'd0;
                load_count_next = 9'd0;
                chain_next      = 6'd0;
            end
            else
            begin
                emit_index_next = emit_index_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= gse_pkg::VolumeRst;
            load_count_reg <= 9'd0;
            emit_index_reg <= 9'd0;
            chain_reg      <= 6'd0;
            track_reg      <= 8'd0;
            sector_reg     <= 4'd0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (volume_we)
            begin
                volume_reg <= volume_wdata;
            end
            load_count_reg <= load_count_next;
            emit_index_reg <= emit_index_next;
            chain_reg      <= chain_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.dp == gse_pkg::DP_CAPTURE && start)
        begin
            in_data_reg   <= data_byte;
            in_track_reg  <= track;
            in_sector_reg <= sector;
        end
        acc_reg    <= acc_next;
        nibble_reg <= nibble_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign done           = done_reg;
    assign nibble         = nibble_reg;
    assign last_of_sector = last_reg;
    assign status         = status_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Request kinds and result status codes as the block uses them
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_PULL = 1'b1
    } req_kind_t;

    typedef enum logic {
        ST_OK        = 1'b0,
        ST_NOT_READY = 1'b1
    } frame_status_t;

    localparam int unsigned StallLimit   = 200;  // idle cycles before the run is declared hung
    localparam int unsigned SettleCycles = 8;    // a load returns nothing, so drain cannot wait on a result for it
    localparam int unsigned MaxReports   = 10;
    localparam int unsigned LastPulls    = 240;  // pulls of the final, partial frame

    // ------------------------------------------------------------------
    // Frame scoreboard: tracks sector contents and frame position, builds
    // the expected result for every pull and checks strobed results
    // in order.
    // ------------------------------------------------------------------
    class frame_scoreboard;
        typedef struct packed {
            logic [7:0]    nibble;
            logic          last_flag;
            frame_status_t status;
        } frame_out_t;

        localparam logic [0:63][7:0] Gcr = {
            8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
            8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
            8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
            8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
            8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
            8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
            8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
            8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
        };

        logic [7:0]  volume;
        logic [7:0]  sector_bytes [256];
        int unsigned bytes_loaded;
        int unsigned frame_pos;
        logic [5:0]  chain;
        logic [7:0]  hdr_track;
        logic [3:0]  hdr_sector;
        frame_out_t  pending [$];
        int unsigned errors;

        function new();
            volume       = gse_pkg::VolumeRst;
            bytes_loaded = 0;
            frame_pos    = 0;
            chain        = '0;
            hdr_track    = '0;
            hdr_sector   = '0;
            errors       = 0;
        endfunction

        function void set_volume(logic [7:0] v);
            volume = v;
        endfunction

        // low two bits of a data byte, swapped
        function logic [1:0] low_pair(logic [7:0] b);
            return {b[0], b[1]};
        endfunction

        // 4-and-4: odd bits first, then even bits, each padded with ones
        function logic [7:0] half_code(logic [7:0] v, bit odd_half);
            return odd_half ? (((v >> 1) & gse_pkg::Mask55) | gse_pkg::MarkAA)
                            : ((v & gse_pkg::Mask55) | gse_pkg::MarkAA);
        endfunction

        function logic [7:0] encode_six(logic [5:0] six);
            logic [7:0] r;
            r     = Gcr[chain ^ six];
            chain = six;
            return r;
        endfunction

        function logic [7:0] next_byte();
            int unsigned p;
            int unsigned k;
            logic [7:0]  hdr_field;
            logic [7:0]  sum;
            logic [5:0]  six;
            p   = frame_pos;
            sum = volume ^ hdr_track ^ {4'd0, hdr_sector};
            if (p < 29) return gse_pkg::SyncByte;
            if (p == 29) return gse_pkg::MarkD5;
            if (p == 30) return gse_pkg::MarkAA;
            if (p == 31) return gse_pkg::Mark96;
            if (p < 40)
            begin
                case ((p - 32) / 2)
                    0:       hdr_field = volume;
                    1:       hdr_field = hdr_track;
                    2:       hdr_field = {4'd0, hdr_sector};
                    default: hdr_field = sum;
                endcase
                return half_code(hdr_field, ((p - 32) % 2) == 0);
            end
            if (p == 40) return gse_pkg::MarkDE;
            if (p == 41) return gse_pkg::MarkAA;
            if (p == 42) return gse_pkg::MarkEB;
            if (p < 51) return gse_pkg::SyncByte;
            if (p < gse_pkg::DataStart)
            begin
                chain = '0;   // chain restarts at the data prologue
                return (p == 51) ? gse_pkg::MarkD5
                                 : ((p == 52) ? gse_pkg::MarkAA : gse_pkg::MarkAD);
            end
            if (p < gse_pkg::UpperStart)
            begin
                k   = p - gse_pkg::DataStart;
                six = {4'd0, low_pair(sector_bytes[k])};
                six[3:2] = low_pair(sector_bytes[k + gse_pkg::AuxCount]);
                if (k + 2 * gse_pkg::AuxCount < gse_pkg::SectorBytes)
                    six[5:4] = low_pair(sector_bytes[k + 2 * gse_pkg::AuxCount]);
                return encode_six(six);
            end
            if (p < gse_pkg::CheckPos)
                return encode_six(sector_bytes[p - gse_pkg::UpperStart][7:2]);
            if (p == gse_pkg::CheckPos) return Gcr[chain];
            if (p == gse_pkg::CheckPos + 1) return gse_pkg::MarkDE;
            if (p == gse_pkg::CheckPos + 2) return gse_pkg::MarkAA;
            if (p == gse_pkg::CheckPos + 3) return gse_pkg::MarkEB;
            return gse_pkg::SyncByte;
        endfunction

        function void note_request(req_kind_t kind, logic [7:0] d,
                                   logic [7:0] trk, logic [3:0] sec);
            frame_out_t e;
            if (kind == ACT_LOAD)
            begin
                // loads while the sector is full (emitting) are dropped
                if (bytes_loaded < gse_pkg::SectorBytes)
                begin
                    if (bytes_loaded == 0)
                    begin
                        hdr_track  = trk;
                        hdr_sector = sec;
                    end
                    sector_bytes[bytes_loaded] = d;
                    bytes_loaded++;
                end
                return;
            end
            if (bytes_loaded < gse_pkg::SectorBytes)
            begin
                e = '{nibble: 8'h00, last_flag: 1'b0, status: ST_NOT_READY};
            end
            else
            begin
                e.nibble = next_byte();
                e.status = ST_OK;
                frame_pos++;
                e.last_flag = (frame_pos == gse_pkg::FrameLen);
                if (e.last_flag)
                begin
                    frame_pos    = 0;
                    bytes_loaded = 0;
                    chain        = '0;
                end
            end
            pending.push_back(e);
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MaxReports) $display("[%0t] %s", $time, msg);
        endfunction

        function void check_result(logic [7:0] nib, logic last_flag, logic st);
            frame_out_t e;
            if (pending.size() == 0)
            begin
                flag_error($sformatf("unexpected result nibble %02h last %0b status %0b",
                                     nib, last_flag, st));
                return;
            end
            e = pending.pop_front();
            if (e.nibble !== nib || e.last_flag !== last_flag || e.status !== st)
                flag_error($sformatf({"mismatch: expected nibble %02h last %0b status %0b, ",
                                      "got nibble %02h last %0b status %0b"},
                                     e.nibble, e.last_flag, e.status, nib, last_flag, st));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals; every input has a known value from time 0
    // ------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       start        = 1'b0;
    logic       action       = 1'b0;
    logic [7:0] data_byte    = '0;
    logic [7:0] track        = '0;
    logic [3:0] sector       = '0;
    logic       volume_we    = 1'b0;
    logic [7:0] volume_wdata = '0;
    logic       busy;
    logic       done;
    logic [7:0] nibble;
    logic       last_of_sector;
    logic       status;

    gcr_six_and_two_sector_encoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .data_byte      (data_byte),
        .track          (track),
        .sector         (sector),
        .volume_we      (volume_we),
        .volume_wdata   (volume_wdata),
        .done           (done),
        .nibble         (nibble),
        .last_of_sector (last_of_sector),
        .status         (status)
    );

    frame_scoreboard sb;
    bit              gaps_on;
    int unsigned     stall_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Results cannot be held off: sample on every strobe. Sampling at the
    // edge sees the values of the cycle that edge closes.
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(nibble, last_of_sector, status);
    end

    // Watchdog: any accepted request or strobed result counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= StallLimit)
            begin
                $display("FAIL gcr_six_and_two_sector_encoder_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Called just after a rising edge; returns just after
    // the edge that accepted the request, leaving start high so the next
    // request can follow back to back. An optional random gap drops start first.
    // ------------------------------------------------------------------
    task automatic send(req_kind_t kind, logic [7:0] d, logic [7:0] trk, logic [3:0] sec);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start     <= 1'b1;
        action    <= kind;
        data_byte <= d;
        track     <= trk;
        sector    <= sec;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(kind, d, trk, sec);
    endtask

    // Stop sending and let every outstanding pull come back; a trailing
    // load may still be in flight, hence the settle time.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_volume(logic [7:0] v);
        drain();
        volume_we    <= 1'b1;
        volume_wdata <= v;
        @(posedge clk);
        volume_we <= 1'b0;
        sb.set_volume(v);
    endtask

    // data bytes lean toward all-zeros and all-ones
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // 256 loads with not-ready pulls sprinkled in (always one on an empty
    // sector and one with a single byte missing).
    task automatic load_sector(logic [7:0] first_trk, logic [3:0] first_sec);
        for (int i = 0; i < gse_pkg::SectorBytes; i++)
        begin
            if (i == 0 || i == gse_pkg::SectorBytes - 1 || $urandom_range(0, 31) == 0)
            begin
                send(ACT_PULL, 8'($urandom), 8'($urandom), 4'($urandom));
            end
            send(ACT_LOAD, pick_byte(),
                 (i == 0) ? first_trk : 8'($urandom),
                 (i == 0) ? first_sec : 4'($urandom));
        end
    endtask

    // Frame pulls with stray loads that the block must ignore
    task automatic pull_frame(int unsigned count);
        for (int unsigned j = 0; j < count; j++)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                send(ACT_LOAD, 8'($urandom), 8'($urandom), 4'($urandom));
            end
            send(ACT_PULL, 8'($urandom), 8'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        sb      = new();
        gaps_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset volume, header fields at their maximum, whole frame
        load_sector(8'hFF, 4'hF);
        pull_frame(gse_pkg::FrameLen);

        // volume at its maximum, header fields at zero; partial frame without idle gaps
        write_volume(8'hFF);
        load_sector(8'h00, 4'h0);
        gaps_on = 1'b0;
        pull_frame(LastPulls);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS gcr_six_and_two_sector_encoder_core");
        else
            $display("FAIL gcr_six_and_two_sector_encoder_core");
        $finish;
    end

endmodule
